// ===== rtl/ihtlp_pkg.sv =====
// shared types and constants of the pid to handle hash table
// no dependencies; imported by the front end, back end, top level and checker
`default_nettype none

package ihtlp_pkg;

   // sizing
   localparam int TABLE_SLOTS_DEFAULT = 64;
   localparam int PID_WIDTH           = 32;
   localparam int HANDLE_WIDTH        = 16;
   localparam int LIVE_WIDTH          = 7;
   localparam int QUEUE_DEPTH         = 2;

   // multiplicative hash constant (golden ratio of 2^32)
   localparam logic [PID_WIDTH-1:0] HASH_MULT = 32'd2654435761;

   // result status codes
   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;

   // slot kinds
   localparam logic [1:0] KIND_EMPTY = 2'd0;
   localparam logic [1:0] KIND_LIVE  = 2'd1;
   localparam logic [1:0] KIND_TOMB  = 2'd2;

   // classified operation
   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_FIND   = 2'd2,
      OP_NONE   = 2'd3
   } op_code_type;

   // request payload
   typedef struct packed {
      logic [1:0]              op;
      logic [PID_WIDTH-1:0]    pid;
      logic [HANDLE_WIDTH-1:0] handle;
   } ihtlp_req_type;

   // response payload
   typedef struct packed {
      logic [1:0]              status;
      logic                    found;
      logic [HANDLE_WIDTH-1:0] result_handle;
      logic [LIVE_WIDTH-1:0]   live_entries;
   } ihtlp_rsp_type;

   // command handed from front to back
   typedef struct packed {
      op_code_type             op;
      logic [PID_WIDTH-1:0]    pid;
      logic [HANDLE_WIDTH-1:0] handle;
   } ihtlp_cmd_type;

   // one table slot as held in the slot ram
   typedef struct packed {
      logic [1:0]              kind;
      logic [PID_WIDTH-1:0]    id;
      logic [HANDLE_WIDTH-1:0] handle;
   } ihtlp_slot_type;

endpackage

`default_nettype wire

// ===== rtl/ihtlp_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module ihtlp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/ihtlp_front.sv =====
// front end: classifies the request and hashes the pid to its home slot
// depends on ihtlp_pkg
`default_nettype none

module ihtlp_front #(
   parameter int TABLE_SLOTS = 64
) (
   input  wire ihtlp_pkg::ihtlp_req_type         req_data,
   output ihtlp_pkg::ihtlp_cmd_type              cmd,
   output logic [$clog2(TABLE_SLOTS)-1:0]        home
);
   import ihtlp_pkg::*;

   localparam int IDX_W = $clog2(TABLE_SLOTS);

   logic [IDX_W-1:0] pid_low;
   logic [IDX_W-1:0] mult_low;

   // op code 3 is carried as a no-operation
   assign cmd = '{op:     op_code_type'(req_data.op),
                  pid:    req_data.pid,
                  handle: req_data.handle};

   // low bits of the product depend only on low bits of the operands
   assign pid_low  = req_data.pid[IDX_W-1:0];
   assign mult_low = HASH_MULT[IDX_W-1:0];
   assign home     = IDX_W'(pid_low * mult_low);

endmodule

`default_nettype wire

// ===== rtl/ihtlp_queue.sv =====
// short command queue between front and back
// no dependencies
`default_nettype none

module ihtlp_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic                  valid,
   output logic                  full,
   output logic      [WIDTH-1:0] head_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign valid     = (count_ff != '0);
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign head_data = slots_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/ihtlp_back.sv =====
// back end: clearing pass, probe sequencer over the slot ram, live count, response
// depends on ihtlp_pkg and ihtlp_ram
`default_nettype none

module ihtlp_back #(
   parameter int TABLE_SLOTS = 64
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              q_valid,
   input  wire ihtlp_pkg::ihtlp_cmd_type          q_cmd,
   input  wire logic [$clog2(TABLE_SLOTS)-1:0]    q_home,
   output logic                                   q_pop,
   output logic                                   clearing,
   output logic                                   rsp_valid,
   output ihtlp_pkg::ihtlp_rsp_type               rsp_data
);
   import ihtlp_pkg::*;

   localparam int IDX_W      = $clog2(TABLE_SLOTS);
   localparam int CNT_W      = $clog2(TABLE_SLOTS + 1);
   localparam int SLOT_W     = $bits(ihtlp_slot_type);
   localparam int FULL_LIMIT = TABLE_SLOTS * 3 / 4;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PROBE
   } state_type;

   state_type        state_ff, state_in;
   ihtlp_cmd_type    cur_ff, cur_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] n_ff, n_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic [CNT_W-1:0] live_ff, live_in;
   logic             rsp_valid_ff, rsp_valid_in;
   ihtlp_rsp_type    rsp_ff, rsp_in;

   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   ihtlp_slot_type    wr_slot;
   logic [IDX_W-1:0]  rd_addr;
   logic [SLOT_W-1:0] rd_raw;
   ihtlp_slot_type    rd_slot;

   logic              fin;
   logic [1:0]        fin_status;
   logic              fin_found;
   logic [HANDLE_WIDTH-1:0] fin_res;
   logic              last_probe;

   // slot store: kind, pid and handle per slot
   ihtlp_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (TABLE_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_slot),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_slot    = ihtlp_slot_type'(rd_raw);
   assign last_probe = &n_ff;
   assign clearing   = (state_ff == ST_CLEAR);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // sequencer: one slot examined per cycle, next slot read issued alongside
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      n_in         = n_ff;
      clr_in       = clr_ff;
      live_in      = live_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      q_pop        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_slot      = rd_slot;
      rd_addr      = IDX_W'(idx_ff + 1'b1);
      fin          = 1'b0;
      fin_status   = STATUS_NOT_FOUND;
      fin_found    = 1'b0;
      fin_res      = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en        = 1'b1;
            wr_addr      = clr_ff;
            wr_slot.kind = KIND_EMPTY;
            clr_in       = IDX_W'(clr_ff + 1'b1);
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            rd_addr = q_home;
            if (q_valid) begin
               q_pop  = 1'b1;
               cur_in = q_cmd;
               idx_in = q_home;
               n_in   = '0;
               if (q_cmd.op == OP_NONE) begin
                  fin = 1'b1;
               end else if (q_cmd.op == OP_INSERT && live_ff >= CNT_W'(FULL_LIMIT)) begin
                  fin        = 1'b1;
                  fin_status = STATUS_FULL;
               end else begin
                  state_in = ST_PROBE;
               end
            end
         end

         ST_PROBE: begin
            unique case (cur_ff.op)
               OP_INSERT: begin
                  if (rd_slot.kind != KIND_LIVE) begin
                     wr_en          = 1'b1;
                     wr_slot.kind   = KIND_LIVE;
                     wr_slot.id     = cur_ff.pid;
                     wr_slot.handle = cur_ff.handle;
                     live_in        = CNT_W'(live_ff + 1'b1);
                     fin            = 1'b1;
                     fin_status     = STATUS_DONE;
                  end else if (last_probe) begin
                     fin        = 1'b1;
                     fin_status = STATUS_FULL;
                  end
               end
               OP_REMOVE: begin
                  if (rd_slot.kind == KIND_EMPTY) begin
                     fin = 1'b1;
                  end else if (rd_slot.kind == KIND_LIVE &&
                               rd_slot.handle == cur_ff.handle) begin
                     wr_en        = 1'b1;
                     wr_slot.kind = KIND_TOMB;
                     if (live_ff != '0) begin
                        live_in = CNT_W'(live_ff - 1'b1);
                     end
                     fin        = 1'b1;
                     fin_status = STATUS_DONE;
                     fin_found  = 1'b1;
                  end else if (last_probe) begin
                     fin = 1'b1;
                  end
               end
               OP_FIND: begin
                  if (rd_slot.kind == KIND_EMPTY) begin
                     fin = 1'b1;
                  end else if (rd_slot.kind == KIND_LIVE && rd_slot.id == cur_ff.pid) begin
                     fin        = 1'b1;
                     fin_status = STATUS_DONE;
                     fin_found  = 1'b1;
                     fin_res    = rd_slot.handle;
                  end else if (last_probe) begin
                     fin = 1'b1;
                  end
               end
               OP_NONE: begin
                  fin = 1'b1;
               end
            endcase
            if (fin) begin
               state_in = ST_IDLE;
            end else begin
               idx_in = IDX_W'(idx_ff + 1'b1);
               n_in   = IDX_W'(n_ff + 1'b1);
            end
         end

         default: begin
            state_in = ST_CLEAR;
         end
      endcase

      // response register load
      if (fin) begin
         rsp_valid_in         = 1'b1;
         rsp_in.status        = fin_status;
         rsp_in.found         = fin_found;
         rsp_in.result_handle = fin_res;
         rsp_in.live_entries  = LIVE_WIDTH'(live_in);
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      idx_ff <= idx_in;
      n_ff   <= n_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/id_hash_table_linear_probe_unit.sv =====
// Pid to task-handle hash table, open addressing with linear probing.
// A request is transferred when start is high and busy is low; each
// response is shown on rsp_data for exactly one cycle with rsp_valid high
// and the receiver cannot stall it, so every strobe must be taken. After
// reset the block runs a clearing pass over every slot of the slot ram
// with busy high. Requests land in a two-entry queue; the back end then
// picks a command and probes slot by slot, since the single slot ram port
// reads one slot per cycle. The response strobe follows in the cycle after
// the command is decided. busy rises while the queue is full.
// depends on ihtlp_pkg, ihtlp_front, ihtlp_queue, ihtlp_back
`default_nettype none

module id_hash_table_linear_probe_unit #(
   parameter int TABLE_SLOTS = ihtlp_pkg::TABLE_SLOTS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire ihtlp_pkg::ihtlp_req_type req_data,
   output logic                          rsp_valid,
   output ihtlp_pkg::ihtlp_rsp_type      rsp_data
);
   import ihtlp_pkg::*;

   localparam int IDX_W = $clog2(TABLE_SLOTS);
   localparam int CMD_W = $bits(ihtlp_cmd_type);
   localparam int QW    = IDX_W + CMD_W;

   ihtlp_cmd_type    front_cmd;
   logic [IDX_W-1:0] front_home;
   logic             push;
   logic             q_full;
   logic             q_valid;
   logic             q_pop;
   logic [QW-1:0]    q_head;
   ihtlp_cmd_type    q_cmd;
   logic [IDX_W-1:0] q_home;
   logic             clearing;

   // request transfer
   assign busy = clearing | q_full;
   assign push = start & ~busy;

   ihtlp_front #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) u_front (
      .req_data (req_data),
      .cmd      (front_cmd),
      .home     (front_home)
   );

   ihtlp_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({front_home, front_cmd}),
      .pop       (q_pop),
      .valid     (q_valid),
      .full      (q_full),
      .head_data (q_head)
   );

   // unpack queue head
   assign q_home = q_head[QW-1:CMD_W];
   assign q_cmd  = ihtlp_cmd_type'(q_head[CMD_W-1:0]);

   ihtlp_back #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_cmd     (q_cmd),
      .q_home    (q_home),
      .q_pop     (q_pop),
      .clearing  (clearing),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== rtl/ihtlp_checker.sv =====
// port-level checks on the hash table unit, bound to the top level
// depends on ihtlp_pkg and id_hash_table_linear_probe_unit
`default_nettype none

module ihtlp_checker (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     busy,
   input wire logic                     rsp_valid,
   input wire ihtlp_pkg::ihtlp_rsp_type rsp_data
);
   import ihtlp_pkg::*;

   // clearing pass holds off requests straight after reset
   a_busy_after_reset: assert property (@(posedge clock)
      reset |=> busy)
      else $error("busy low right after reset");

   // no response can follow a reset cycle
   a_no_rsp_after_reset: assert property (@(posedge clock)
      rsp_valid |-> !$past(reset))
      else $error("response strobe straight after reset");

   // a located entry always reports done
   a_found_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.found) |-> (rsp_data.status == STATUS_DONE))
      else $error("found set without done status");

   // refused insert and misses carry no handle and no found flag
   a_miss_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != STATUS_DONE) |->
         (!rsp_data.found && rsp_data.result_handle == '0))
      else $error("miss or refusal with handle or found flag");

   // status code three is never produced
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == STATUS_DONE ||
                     rsp_data.status == STATUS_NOT_FOUND ||
                     rsp_data.status == STATUS_FULL))
      else $error("undefined status code");

endmodule

bind id_hash_table_linear_probe_unit ihtlp_checker u_ihtlp_checker (.*);

`default_nettype wire
